// ===== rtl/core/pcd_pkg.sv =====
`default_nettype none

package pcd_pkg;

  localparam logic [31:0] CwIdle    = 32'h7A89_C197;
  localparam logic [31:0] CwSync    = 32'h7CD2_15D8;
  localparam int unsigned AddrWidth = 21;
  localparam int unsigned DataBits  = 20;
  localparam int unsigned StepBits  = 4;

  typedef enum logic [1:0] {
    CFG_FILTER_ADDR = 2'd0,
    CFG_FILTER_MASK = 2'd1,
    CFG_INVERT      = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    EV_ADDR = 2'd0,
    EV_CHAR = 2'd1,
    EV_END  = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    JOB_ADDR = 2'd0,
    JOB_IDLE = 2'd1,
    JOB_DATA = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e              kind;
    logic                   numeric;
    logic [AddrWidth-1:0]   addr;
    logic [1:0]             fn;
    logic [DataBits-1:0]    data;
  } job_t;

  typedef struct packed {
    event_kind_e            kind;
    logic [6:0]             char_value;
    logic [AddrWidth-1:0]   addr;
    logic [1:0]             fn;
    logic                   last;
  } result_t;

  function automatic logic [6:0] bcd_char(input logic [3:0] v);
    logic [6:0] c;
    case (v)
      4'hA:    c = 7'h2A;
      4'hB:    c = 7'h55;
      4'hC:    c = 7'h20;
      4'hD:    c = 7'h2D;
      4'hE:    c = 7'h29;
      4'hF:    c = 7'h28;
      default: c = 7'h30 + {3'b000, v};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pcd_fifo.sv =====
`default_nettype none

module pcd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("fifo count beyond depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> !empty_o)
    else $error("fifo empty after a lone push");

endmodule

`default_nettype wire

// ===== rtl/core/pcd_front.sv =====
`default_nettype none

module pcd_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [pcd_pkg::AddrWidth-1:0] cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic [31:0]                   codeword_i,
  output logic                               job_push_o,
  output pcd_pkg::job_t                      job_o
);

  import pcd_pkg::*;

  logic [AddrWidth-1:0] filt_addr_q, filt_mask_q;
  logic                 invert_q;
  logic                 in_msg_q, in_msg_d;
  logic                 numeric_q, numeric_d;
  logic [4:0]           fpos_q, fpos_d;
  logic [31:0]          word;
  logic [AddrWidth-1:0] addr;
  logic                 is_sync, is_idle;

  // polarity register at 0 means the line is inverted
  assign word    = invert_q ? codeword_i : ~codeword_i;
  assign is_sync = (word == CwSync);
  assign is_idle = (word == CwIdle);
  // frame slot is (position after increment - 1) / 2, i.e. the old position
  assign addr    = {word[30:13], fpos_q[3:1]};

  always_comb begin
    in_msg_d     = in_msg_q;
    numeric_d    = numeric_q;
    fpos_d       = fpos_q + 5'd1;
    job_push_o   = 1'b0;
    job_o.kind   = JOB_DATA;
    job_o.numeric = numeric_q;
    job_o.addr   = addr;
    job_o.fn     = word[12:11];
    job_o.data   = word[30:11];
    if (is_sync) begin
      fpos_d = '0;
    end else if (!in_msg_q) begin
      if (!is_idle && !word[31] && (((addr ^ filt_addr_q) & filt_mask_q) == '0)) begin
        in_msg_d   = 1'b1;
        numeric_d  = (word[12:11] == 2'b00);
        job_push_o = accept_i;
        job_o.kind = JOB_ADDR;
      end
    end else if (is_idle) begin
      in_msg_d   = 1'b0;
      job_push_o = accept_i;
      job_o.kind = JOB_IDLE;
    end else begin
      job_push_o = accept_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_addr_q <= '0;
      filt_mask_q <= '1;
      invert_q    <= 1'b0;
      in_msg_q    <= 1'b0;
      numeric_q   <= 1'b0;
      fpos_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FILTER_ADDR: filt_addr_q <= cfg_data_i;
          CFG_FILTER_MASK: filt_mask_q <= cfg_data_i;
          CFG_INVERT:      invert_q    <= cfg_data_i[0];
          default:         ;
        endcase
      end
      if (accept_i) begin
        in_msg_q  <= in_msg_d;
        numeric_q <= numeric_d;
        fpos_q    <= fpos_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcd_back.sv =====
`default_nettype none

module pcd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_empty_i,
  input  wire pcd_pkg::job_t  job_i,
  output logic                job_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output pcd_pkg::result_t    res_o
);

  import pcd_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DATA
  } state_e;

  state_e                state_q;
  logic [2:0]            step_q;
  logic [DataBits-1:0]   data_q;
  logic                  numeric_q;
  logic [2:0]            cnt_q, cnt_d;
  logic [6:0]            acc_q, acc_d;
  logic [2:0]            size;
  logic [6:0]            sym_acc, sym;
  logic                  got;
  logic [4:0]            rem_bits;
  logic                  last_sym;

  assign size = numeric_q ? 3'd4 : 3'd7;

  // one nibble of the symbol stream per step, at most one symbol completes
  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    got     = 1'b0;
    sym_acc = '0;
    for (int i = 0; i < StepBits; i++) begin
      acc_d = {acc_d[5:0], data_q[DataBits-1-i]};
      cnt_d = cnt_d + 3'd1;
      if (cnt_d == size) begin
        sym_acc = acc_d;
        got     = 1'b1;
        acc_d   = '0;
        cnt_d   = '0;
      end
    end
  end

  // symbols go out lsb first, so reverse within the symbol size
  always_comb begin
    sym = '0;
    for (int i = 0; i < 7; i++) begin
      if (numeric_q) begin
        if (i < 4) sym[i] = sym_acc[3-i];
      end else begin
        sym[i] = sym_acc[6-i];
      end
    end
  end

  assign rem_bits = 5'd16 - {step_q, 2'b00};
  assign last_sym = ({3'b000, cnt_d} + {1'b0, rem_bits}) < {3'b000, size};

  always_comb begin
    job_pop_o        = 1'b0;
    res_push_o       = 1'b0;
    res_o.kind       = EV_CHAR;
    res_o.char_value = numeric_q ? bcd_char(sym[3:0]) : sym;
    res_o.addr       = '0;
    res_o.fn         = '0;
    res_o.last       = last_sym;
    case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          case (job_i.kind)
            JOB_ADDR: begin
              res_o.kind       = EV_ADDR;
              res_o.char_value = '0;
              res_o.addr       = job_i.addr;
              res_o.fn         = job_i.fn;
              res_o.last       = 1'b1;
              res_push_o       = !res_full_i;
              job_pop_o        = !res_full_i;
            end
            JOB_IDLE: begin
              res_o.kind       = EV_END;
              res_o.char_value = '0;
              res_o.last       = 1'b1;
              res_push_o       = !res_full_i;
              job_pop_o        = !res_full_i;
            end
            default: job_pop_o = 1'b1;
          endcase
        end
      end
      S_DATA: res_push_o = got && !res_full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      numeric_q <= 1'b0;
      cnt_q     <= '0;
      acc_q     <= '0;
      data_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (job_pop_o) begin
            if (job_i.kind == JOB_DATA) begin
              state_q   <= S_DATA;
              step_q    <= '0;
              numeric_q <= job_i.numeric;
              data_q    <= job_i.data;
            end else begin
              // held symbol bits are dropped at a new match or message end
              cnt_q <= '0;
              acc_q <= '0;
            end
          end
        end
        S_DATA: begin
          if (!got || !res_full_i) begin
            cnt_q  <= cnt_d;
            acc_q  <= acc_d;
            data_q <= {data_q[DataBits-StepBits-1:0], {StepBits{1'b0}}};
            step_q <= step_q + 3'd1;
            if (step_q == 3'(DataBits / StepBits - 1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_carry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd6)
    else $error("held bit count reached a whole symbol");

  a_carry_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && job_pop_o && job_i.kind != JOB_DATA) |=> cnt_q == '0)
    else $error("held bits survived a match or message end");

endmodule

`default_nettype wire

// ===== rtl/core/pocsag_codeword_decoder.sv =====
`default_nettype none

// pocsag codeword decoder, receive side
// input channel: drive codeword_i and raise push; a transfer happens on a
// clock edge with push high and full low. output channel: while empty is low
// the oldest event sits on the result ports; pop high on an edge takes it.
// configuration: cfg_we_i with cfg_index_i (0 filter address, 1 filter mask,
// 2 polarity) and cfg_data_i; the user writes these only while the block is
// idle, which the block itself does not enforce. the front classifies each
// codeword in the cycle it is taken and posts a job into a short queue; the
// back turns address and idle jobs into one event each and unpacks a message
// codeword four data bits a cycle, pausing while a finished character meets
// a full result queue; a message word yields up to five characters. message
// data throughput is set by the nibble-serial unpacker, which takes no new
// job until it is done with a message word; sync, idle-while-hunting and
// unmatched words are dropped by the front and cost no back time.
// reset empties both queues, returns to address hunting and sets the filter
// to address zero with every bit compared. when pop is held low the result
// queue fills, the back stalls, then the job queue fills and full rises.
module pocsag_codeword_decoder #(
  parameter int unsigned JobDepth = 2,
  parameter int unsigned ResDepth = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [pcd_pkg::AddrWidth-1:0] cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [31:0]                   codeword_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [1:0]                         event_kind_o,
  output logic [6:0]                         char_value_o,
  output logic [pcd_pkg::AddrWidth-1:0]      matched_address_o,
  output logic [1:0]                         function_bits_o,
  output logic                               last_o
);

  import pcd_pkg::*;

  logic    accept;
  logic    job_push, job_pop, job_empty;
  job_t    job_in, job_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign accept = push && !full;

  pcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .codeword_i  (codeword_i),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  pcd_fifo #(
    .Width ($bits(job_t)),
    .Depth (JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  pcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pcd_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign event_kind_o      = res_out.kind;
  assign char_value_o      = res_out.char_value;
  assign matched_address_o = res_out.addr;
  assign function_bits_o   = res_out.fn;
  assign last_o            = res_out.last;

endmodule

`default_nettype wire

// ===== tb/sv/pcd_event_checker.sv =====
module pcd_event_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [pcd_pkg::AddrWidth-1:0] cfg_data_i,
  input  wire logic                          push,
  input  wire logic                          full,
  input  wire logic [31:0]                   codeword_i,
  input  wire logic                          empty,
  input  wire logic                          pop,
  input  wire logic [1:0]                    event_kind_i,
  input  wire logic [6:0]                    char_value_i,
  input  wire logic [pcd_pkg::AddrWidth-1:0] matched_address_i,
  input  wire logic [1:0]                    function_bits_i,
  input  wire logic                          last_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        events_o
);

  import pcd_pkg::*;

  // register copies
  logic [AddrWidth-1:0] filt_addr;
  logic [AddrWidth-1:0] filt_mask;
  logic                 keep_polarity;

  // decoder state
  logic                 in_msg;
  logic [4:0]           frame_pos;
  logic                 numeric;
  logic [2:0]           carry_cnt;
  logic [6:0]           carry_bits;

  result_t              event_q[$];
  int unsigned          fails = 0;
  int unsigned          pend = 0;
  int unsigned          seen = 0;

  assign fail_count_o = fails;
  assign pending_o    = pend;
  assign events_o     = seen;

  task automatic decode_codeword(input logic [31:0] rx);
    logic [31:0]          w;
    logic [4:0]           slot_pos;
    logic [AddrWidth-1:0] addr;
    logic [6:0]           acc;
    logic [2:0]           cnt;
    logic [3:0]           nib;
    logic [6:0]           ch;
    result_t              held;
    bit                   have_held;
    w = keep_polarity ? rx : ~rx;
    frame_pos = frame_pos + 5'd1;
    have_held = 1'b0;
    held = '0;
    if (w == CwSync) begin
      frame_pos = '0;
    end else if (!in_msg) begin
      // slot is half of (the count since sync, minus one), wrapping at 8
      slot_pos = frame_pos - 5'd1;
      addr = {w[30:13], slot_pos[3:1]};
      if (w != CwIdle && !w[31] && ((addr ^ filt_addr) & filt_mask) == '0) begin
        in_msg = 1'b1;
        numeric = (w[12:11] == 2'd0);
        carry_cnt = '0;
        carry_bits = '0;
        event_q.push_back('{kind: EV_ADDR, char_value: '0, addr: addr, fn: w[12:11],
                            last: 1'b1});
      end
    end else if (w == CwIdle) begin
      in_msg = 1'b0;
      carry_cnt = '0;
      carry_bits = '0;
      event_q.push_back('{kind: EV_END, char_value: '0, addr: '0, fn: '0, last: 1'b1});
    end else begin
      acc = carry_bits;
      cnt = carry_cnt;
      for (int b = 30; b >= 11; b--) begin
        acc = {acc[5:0], w[b]};
        cnt = cnt + 3'd1;
        if (cnt == (numeric ? 3'd4 : 3'd7)) begin
          // symbols go out lsb first, so mirror what was shifted in
          if (numeric) begin
            nib = {<<{acc[3:0]}};
            case (nib)
              4'd10:   ch = 7'h2A; // star
              4'd11:   ch = 7'h55; // U
              4'd12:   ch = 7'h20; // space
              4'd13:   ch = 7'h2D; // dash
              4'd14:   ch = 7'h29; // close bracket
              4'd15:   ch = 7'h28; // open bracket
              default: ch = {3'b011, nib};
            endcase
          end else begin
            ch = {<<{acc}};
          end
          if (have_held) event_q.push_back(held);
          held = '{kind: EV_CHAR, char_value: ch, addr: '0, fn: '0, last: 1'b0};
          have_held = 1'b1;
          acc = '0;
          cnt = '0;
        end
      end
      carry_bits = acc;
      carry_cnt = cnt;
      if (have_held) begin
        held.last = 1'b1;
        event_q.push_back(held);
      end
    end
  endtask

  function automatic void compare_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  task automatic check_event();
    result_t want;
    seen++;
    if (event_q.size() == 0) begin
      fails++;
      $display("%0t: expected no event, actual kind %0d char %0h addr %0h fn %0d last %0b",
               $time, event_kind_i, char_value_i, matched_address_i, function_bits_i,
               last_i);
    end else begin
      want = event_q.pop_front();
      compare_field("event_kind", 32'(want.kind), 32'(event_kind_i));
      compare_field("char_value", 32'(want.char_value), 32'(char_value_i));
      compare_field("matched_address", 32'(want.addr), 32'(matched_address_i));
      compare_field("function_bits", 32'(want.fn), 32'(function_bits_i));
      compare_field("last", 32'(want.last), 32'(last_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_addr = '0;
      filt_mask = '1;
      keep_polarity = 1'b0;
      in_msg = 1'b0;
      frame_pos = '0;
      numeric = 1'b0;
      carry_cnt = '0;
      carry_bits = '0;
      event_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FILTER_ADDR: filt_addr = cfg_data_i;
          CFG_FILTER_MASK: filt_mask = cfg_data_i;
          CFG_INVERT:      keep_polarity = cfg_data_i[0];
          default: ;
        endcase
      end
      if (push && !full) decode_codeword(codeword_i);
      if (pop && !empty) check_event();
    end
    pend = event_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import pcd_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 16;
  localparam logic [1:0]  CfgSpare    = 2'd3; // no register behind this index

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [1:0]           cfg_index_i = CFG_FILTER_ADDR;
  logic [AddrWidth-1:0] cfg_data_i  = '0;
  logic                 push        = 1'b0;
  logic [31:0]          codeword_i  = '0;
  logic                 pop         = 1'b0;
  logic                 full;
  logic                 empty;
  logic [1:0]           event_kind_o;
  logic [6:0]           char_value_o;
  logic [AddrWidth-1:0] matched_address_o;
  logic [1:0]           function_bits_o;
  logic                 last_o;

  int unsigned          fails;
  int unsigned          pending;
  int unsigned          events;

  // flow control, percent of cycles spent idle
  int unsigned          send_gap = 26;
  int unsigned          recv_gap = 56;

  // what the block has been told, so words can be put on air the right way up
  logic                 keep_pol = 1'b0;
  logic [AddrWidth-1:0] filt_sh  = '0;
  logic [AddrWidth-1:0] mask_sh  = '1;

  int unsigned          words_sent = 0;
  int unsigned          padding    = 0;
  int unsigned          idle_run   = 0;

  pocsag_codeword_decoder dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .push,
    .full,
    .codeword_i,
    .empty,
    .pop,
    .event_kind_o,
    .char_value_o,
    .matched_address_o,
    .function_bits_o,
    .last_o
  );

  pcd_event_checker event_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .push,
    .full,
    .codeword_i,
    .empty,
    .pop,
    .event_kind_i      (event_kind_o),
    .char_value_i      (char_value_o),
    .matched_address_i (matched_address_o),
    .function_bits_i   (function_bits_o),
    .last_i            (last_o),
    .fail_count_o      (fails),
    .pending_o         (pending),
    .events_o          (events)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      pop <= ($urandom_range(99) >= recv_gap);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (push && !full) || (pop && !empty)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d events outstanding",
               $time, IdleLimit, pending);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // all driving tasks start and end just after a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [AddrWidth-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_FILTER_ADDR: filt_sh = val;
      CFG_FILTER_MASK: mask_sh = val;
      CFG_INVERT:      keep_pol = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [AddrWidth-1:0] addr, input logic [AddrWidth-1:0] mask,
                           input logic [AddrWidth-1:0] pol);
    write_reg(CFG_FILTER_ADDR, addr);
    write_reg(CFG_FILTER_MASK, mask);
    write_reg(CFG_INVERT, pol);
  endtask

  // w is the codeword as the decoder should see it after polarity handling
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(99) < send_gap) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push       <= 1'b1;
    codeword_i <= keep_pol ? w : ~w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] addr_word(input logic [17:0] a, input logic [1:0] fn);
    return {1'b0, a, fn, 11'($urandom)};
  endfunction

  function automatic logic [31:0] data_word(input logic [19:0] d);
    return {1'b1, d, 11'($urandom)};
  endfunction

  function automatic logic [17:0] near_filter();
    return (filt_sh[20:3] & mask_sh[20:3]) | (18'($urandom) & ~mask_sh[20:3]);
  endfunction

  // usually sync, pad to filter slot, address, mostly data words, usually idle
  task automatic send_message();
    logic [2:0]  slot;
    logic [17:0] a;
    slot = (filt_sh[2:0] & mask_sh[2:0]) | (3'($urandom) & ~mask_sh[2:0]);
    if ($urandom_range(9) != 0) begin
      send_word(CwSync);
      repeat (2 * int'(slot) + $urandom_range(1)) begin
        send_word(CwIdle);
        padding++;
      end
    end
    a = ($urandom_range(3) != 0) ? near_filter() : 18'($urandom);
    send_word(addr_word(a, 2'($urandom)));
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(9))
        0:       send_word(CwSync);
        1:       send_word(addr_word(18'($urandom), 2'($urandom)));
        default: send_word(data_word(20'($urandom)));
      endcase
    end
    if ($urandom_range(9) != 0) send_word(CwIdle);
  endtask

  // long stretch without sync so the frame count wraps
  task automatic send_long_run();
    send_word(CwSync);
    repeat (($urandom_range(1) == 0) ? 31 : $urandom_range(45, 20)) begin
      send_word(CwIdle);
      padding++;
    end
    send_word(addr_word(near_filter(), 2'($urandom)));
    repeat ($urandom_range(3)) send_word(data_word(20'($urandom)));
    send_word(CwIdle);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop;
    stop = words_sent + count;
    while (words_sent < stop) begin
      case ($urandom_range(9))
        0, 1: repeat ($urandom_range(8, 1)) send_word($urandom);
        2:    send_long_run();
        default: send_message();
      endcase
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: inverted line, only address 0 in slot 0 matches
    send_word(data_word(20'hFFFFF));       // message word while hunting
    send_word(CwIdle);
    send_word(CwSync);
    send_word(addr_word(18'h3FFFF, 2'd0)); // no match
    send_word(CwSync);
    send_word(addr_word(18'h00000, 2'd0)); // numeric message
    send_word(data_word(20'h084C2));       // digits 0 to 4
    send_word(data_word(20'hA6E19));       // digits 5 to 9
    send_word(CwSync);                     // skipped inside a message
    send_word(data_word(20'h5D3B7));       // punctuation values
    send_word(addr_word(18'h3FFFF, 2'd3)); // address word taken as data
    send_word(data_word(20'h00000));
    send_word(CwIdle);                     // end of message
    send_word(CwSync);
    send_word(CwIdle);
    send_word(addr_word(18'h00000, 2'd3)); // alphanumeric message
    send_word(data_word(20'hFFFFF));
    send_word(CwSync);                     // held bits carry across sync
    send_word(data_word(20'h00000));
    send_word(data_word(20'h5A5A5));
    send_word(CwIdle);                     // held bits dropped
    send_word(addr_word(18'h00000, 2'd1)); // wrong slot
    send_word(data_word(20'h12345));
    settle();

    configure('1, '1, 21'd1);
    write_reg(CfgSpare, 21'($urandom));
    run_random(40);
    settle();                              // sender holds off until all events are out
    run_random(40);
    settle();

    send_gap = 56;
    recv_gap = 26;
    configure(21'($urandom), 21'($urandom), 21'h1FFFFE);
    run_random(80);
    settle();

    send_gap = 0;
    recv_gap = 0;
    configure('0, '0, 21'h000003);
    write_reg(CfgSpare, '1);
    run_random(80);
    settle();

    $display("sent %0d codewords, %0d of them idle fill, and checked %0d events",
             words_sent, padding, events);
    $display("four register settings, both polarities, three flow-control patterns");
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
